// ===== sv/lpbm_pkg.sv =====
// Shared types and codes for the LRU page buffer manager.
package lpbm_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_PICK,
        ST_LOCATE,
        ST_APPLY,
        ST_RESP
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_DEC,
        OP_DIRTY,
        OP_APPEND,
        OP_MOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     dirty_val;
    } cell_ctrl_t;

    localparam logic [2:0] CMD_FIX         = 3'd0;
    localparam logic [2:0] CMD_FIX_NEW     = 3'd1;
    localparam logic [2:0] CMD_UNFIX       = 3'd2;
    localparam logic [2:0] CMD_SET_DIRTY   = 3'd3;
    localparam logic [2:0] CMD_UNSET_DIRTY = 3'd4;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_NOT_RES    = 2'd1;
    localparam logic [1:0] STAT_ALL_PINNED = 2'd2;

    localparam int CMD_W    = 3;
    localparam int FRAME_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

endpackage

// ===== sv/lpbm_cell.sv =====
// One LRU position of the frame chain: tag, pin count, dirty mark and frame id.
module lpbm_cell #(
    parameter int INDEX     = 0,
    parameter int FRAMES    = 64,
    parameter int PAGE_BITS = 20,
    parameter int PIN_BITS  = 16
) (
    input  logic                         aclk,
    input  lpbm_pkg::cell_ctrl_t         ctrl,
    input  logic [$clog2(FRAMES)-1:0]    sel,
    input  logic [$clog2(FRAMES)-1:0]    last,
    input  logic [$clog2(FRAMES+1)-1:0]  count,
    input  logic [PAGE_BITS-1:0]         page_key,
    input  logic [$clog2(FRAMES)-1:0]    fid_key,
    input  logic [PAGE_BITS-1:0]         nb_tag,
    input  logic [PIN_BITS-1:0]          nb_pin,
    input  logic                         nb_dirty,
    input  logic [$clog2(FRAMES)-1:0]    nb_fid,
    input  logic [PAGE_BITS-1:0]         wr_tag,
    input  logic [PIN_BITS-1:0]          wr_pin,
    input  logic                         wr_dirty,
    input  logic [$clog2(FRAMES)-1:0]    wr_fid,
    output logic [PAGE_BITS-1:0]         tag,
    output logic [PIN_BITS-1:0]          pin,
    output logic                         dirty,
    output logic [$clog2(FRAMES)-1:0]    fid,
    output logic                         tag_match,
    output logic                         unpinned,
    output logic                         fid_match
);
    import lpbm_pkg::*;

    localparam int FW = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES+1);
    localparam logic [FW-1:0] POS = FW'(INDEX);

    logic [PAGE_BITS-1:0] tag_reg, tag_next;
    logic [PIN_BITS-1:0]  pin_reg, pin_next;
    logic                 dirty_reg, dirty_next;
    logic [FW-1:0]        fid_reg, fid_next;
    logic                 resident;

    assign resident  = CW'(INDEX) < count;
    assign tag_match = resident && (tag_reg == page_key);
    assign unpinned  = resident && (pin_reg == '0);
    assign fid_match = resident && (fid_reg == fid_key);

    assign tag   = tag_reg;
    assign pin   = pin_reg;
    assign dirty = dirty_reg;
    assign fid   = fid_reg;

    always_comb begin
        tag_next   = tag_reg;
        pin_next   = pin_reg;
        dirty_next = dirty_reg;
        fid_next   = fid_reg;
        case (ctrl.op)
            OP_DEC: begin
                if (POS == sel && pin_reg != '0) pin_next = pin_reg - 1'b1;
            end
            OP_DIRTY: begin
                if (POS == sel) dirty_next = ctrl.dirty_val;
            end
            OP_APPEND: begin
                if (POS == sel) begin
                    tag_next   = wr_tag;
                    pin_next   = wr_pin;
                    dirty_next = wr_dirty;
                    fid_next   = wr_fid;
                end
            end
            OP_MOVE: begin
                // close the gap at sel and drop the moved entry at the MRU end
                if (POS == last) begin
                    tag_next   = wr_tag;
                    pin_next   = wr_pin;
                    dirty_next = wr_dirty;
                    fid_next   = wr_fid;
                end else if (POS >= sel && POS < last) begin
                    tag_next   = nb_tag;
                    pin_next   = nb_pin;
                    dirty_next = nb_dirty;
                    fid_next   = nb_fid;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        tag_reg   <= tag_next;
        pin_reg   <= pin_next;
        dirty_reg <= dirty_next;
        fid_reg   <= fid_next;
    end

endmodule

// ===== sv/lru_page_buffer_manager_core.sv =====
// Top level of the LRU page buffer manager: command sequencer over a chain of frame cells.
//
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+------------------------------------------
//  s_        | in  | s_tvalid / s_tready    | s_tdata: command, page_number, target_frame
//  m_        | out | m_tvalid / m_tready    | m_tdata: frame_number .. frames_allocated
//  cfg_      | in  | cfg_valid / cfg_ready  | cfg_data: pool_size
//
// Each request steps through match, pick, locate and apply after acceptance before a
// valid result is shown, and the result then waits on m_tready; the next request is
// taken in the cycle after the result leaves. The chain cells keep LRU order by
// position, least recent at cell 0, and a move shifts the cells above it down one.
// Reset (aresetn low, synchronous) empties the pool and sets pool_size to 64; the
// frame stores need no clearing pass.
module lru_page_buffer_manager_core #(
    parameter int FRAMES    = 64,
    parameter int PAGE_BITS = 20,
    parameter int PIN_BITS  = 16,
    localparam int IN_W     = 9 + PAGE_BITS,
    localparam int IN_DW    = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W    = 18 + PAGE_BITS,
    localparam int OUT_DW   = ((OUT_W + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // command[2:0], page_number[PAGE_BITS-1:0], target_frame[5:0], zero fill
    input  logic [IN_DW-1:0]  s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // frame_number[5:0], hit, read_request, writeback_request,
    // evicted_page[PAGE_BITS-1:0], status[1:0], frames_allocated[6:0], zero fill
    output logic [OUT_DW-1:0] m_tdata,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [6:0]        cfg_data
);
    import lpbm_pkg::*;

    localparam int FW = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES+1);
    localparam logic [PIN_BITS-1:0] PIN_MAX = '1;
    localparam logic [PIN_BITS-1:0] PIN_ONE = PIN_BITS'(1);

    state_t state_reg, state_next;

    logic [CMD_W-1:0]     cmd_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [FRAME_W-1:0]   tf_reg;
    logic [CW-1:0]        n_reg, n_next;
    logic [COUNT_W-1:0]   pool_reg;

    logic [FRAMES-1:0] match_vec_reg, free_vec_reg;
    logic [FW-1:0]     hit_f_reg, vic_pos_reg, key_reg, loc_pos_reg;
    logic              hit_found_reg, vic_found_reg;

    logic [FRAME_W-1:0]   res_frame_reg;
    logic                 res_hit_reg, res_read_reg, res_wb_reg;
    logic [PAGE_BITS-1:0] res_evict_reg;
    logic [STATUS_W-1:0]  res_status_reg;
    logic [COUNT_W-1:0]   res_alloc_reg;

    logic [PAGE_BITS-1:0] tag_arr   [FRAMES];
    logic [PIN_BITS-1:0]  pin_arr   [FRAMES];
    logic                 dirty_arr [FRAMES];
    logic [FW-1:0]        fid_arr   [FRAMES];
    logic [FRAMES-1:0]    tag_match_vec, unpinned_vec, fid_match_vec;

    cell_ctrl_t           ctrl;
    logic [FW-1:0]        sel, last;
    logic [PAGE_BITS-1:0] wr_tag;
    logic [PIN_BITS-1:0]  wr_pin;
    logic                 wr_dirty;
    logic [FW-1:0]        wr_fid;

    logic [FRAMES-1:0] by_frame;
    logic [FW-1:0]     hit_f, vic_pos, loc_pos;
    logic              hit_found, vic_found;

    logic [FRAME_W-1:0]   res_frame;
    logic                 res_hit, res_read, res_wb;
    logic [PAGE_BITS-1:0] res_evict;
    logic [STATUS_W-1:0]  res_status;
    logic                 can_alloc, is_fix, is_new;
    cell_op_t             apply_op;

    // chain of cells, each fed by its upper neighbor (the top cell by itself)
    for (genvar i = 0; i < FRAMES; i++) begin : g_cell
        localparam int NB = (i == FRAMES - 1) ? i : i + 1;
        lpbm_cell #(
            .INDEX(i), .FRAMES(FRAMES), .PAGE_BITS(PAGE_BITS), .PIN_BITS(PIN_BITS)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .sel      (sel),
            .last     (last),
            .count    (n_reg),
            .page_key (page_reg),
            .fid_key  (key_reg),
            .nb_tag   (tag_arr[NB]),
            .nb_pin   (pin_arr[NB]),
            .nb_dirty (dirty_arr[NB]),
            .nb_fid   (fid_arr[NB]),
            .wr_tag   (wr_tag),
            .wr_pin   (wr_pin),
            .wr_dirty (wr_dirty),
            .wr_fid   (wr_fid),
            .tag      (tag_arr[i]),
            .pin      (pin_arr[i]),
            .dirty    (dirty_arr[i]),
            .fid      (fid_arr[i]),
            .tag_match(tag_match_vec[i]),
            .unpinned (unpinned_vec[i]),
            .fid_match(fid_match_vec[i])
        );
    end

    // lowest frame id of tag matches; lowest position of unpinned and of fid matches
    always_comb begin
        by_frame  = '0;
        hit_f     = '0;
        hit_found = 1'b0;
        vic_pos   = '0;
        vic_found = 1'b0;
        loc_pos   = '0;
        for (int j = 0; j < FRAMES; j++) begin
            for (int i = 0; i < FRAMES; i++) begin
                if (match_vec_reg[i] && fid_arr[i] == FW'(j)) by_frame[j] = 1'b1;
            end
        end
        for (int j = FRAMES - 1; j >= 0; j--) begin
            if (by_frame[j]) begin
                hit_f     = FW'(j);
                hit_found = 1'b1;
            end
            if (free_vec_reg[j]) begin
                vic_pos   = FW'(j);
                vic_found = 1'b1;
            end
            if (fid_match_vec[j]) loc_pos = FW'(j);
        end
    end

    // decide the chain operation and the result
    always_comb begin
        is_fix     = (cmd_reg == CMD_FIX);
        is_new     = (cmd_reg == CMD_FIX_NEW);
        can_alloc  = (8'(n_reg) < 8'(pool_reg)) && (n_reg < CW'(FRAMES));
        apply_op   = OP_NONE;
        sel        = loc_pos_reg;
        last       = FW'(n_reg - CW'(1));
        wr_tag     = page_reg;
        wr_pin     = PIN_ONE;
        wr_dirty   = is_new;
        wr_fid     = FW'(n_reg);
        n_next     = n_reg;
        res_frame  = '0;
        res_hit    = 1'b0;
        res_read   = 1'b0;
        res_wb     = 1'b0;
        res_evict  = '0;
        res_status = STAT_OK;
        case (cmd_reg)
            CMD_FIX, CMD_FIX_NEW: begin
                if (is_fix && hit_found_reg) begin
                    apply_op  = OP_MOVE;
                    wr_tag    = tag_arr[loc_pos_reg];
                    wr_pin    = (pin_arr[loc_pos_reg] == PIN_MAX) ? PIN_MAX
                                : pin_arr[loc_pos_reg] + 1'b1;
                    wr_dirty  = dirty_arr[loc_pos_reg];
                    wr_fid    = hit_f_reg;
                    res_frame = FRAME_W'(hit_f_reg);
                    res_hit   = 1'b1;
                end else if (can_alloc) begin
                    apply_op  = OP_APPEND;
                    sel       = FW'(n_reg);
                    n_next    = n_reg + CW'(1);
                    res_frame = FRAME_W'(n_reg);
                    res_read  = is_fix;
                end else if (vic_found_reg) begin
                    apply_op  = OP_MOVE;
                    sel       = vic_pos_reg;
                    wr_fid    = fid_arr[vic_pos_reg];
                    res_frame = FRAME_W'(fid_arr[vic_pos_reg]);
                    res_read  = is_fix;
                    res_wb    = dirty_arr[vic_pos_reg];
                    if (dirty_arr[vic_pos_reg]) res_evict = tag_arr[vic_pos_reg];
                end else begin
                    res_status = STAT_ALL_PINNED;
                end
            end
            CMD_UNFIX: begin
                if (hit_found_reg) begin
                    apply_op  = OP_DEC;
                    res_frame = FRAME_W'(hit_f_reg);
                end else begin
                    res_status = STAT_NOT_RES;
                end
            end
            CMD_SET_DIRTY, CMD_UNSET_DIRTY: begin
                if (8'(tf_reg) < 8'(n_reg)) begin
                    apply_op  = OP_DIRTY;
                    res_frame = tf_reg;
                end else begin
                    res_status = STAT_NOT_RES;
                end
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_MATCH;
            ST_MATCH:  state_next = ST_PICK;
            ST_PICK:   state_next = ST_LOCATE;
            ST_LOCATE: state_next = ST_APPLY;
            ST_APPLY:  state_next = ST_RESP;
            ST_RESP:   if (m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready       = 1'b0;
        m_tvalid       = 1'b0;
        ctrl.op        = OP_NONE;
        ctrl.dirty_val = (cmd_reg == CMD_SET_DIRTY);
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_APPLY: ctrl.op  = apply_op;
            ST_RESP:  m_tvalid = 1'b1;
            default: ;
        endcase
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            pool_reg  <= COUNT_W'(64);
        end else begin
            state_reg <= state_next;
            if (cfg_valid) pool_reg <= cfg_data;
            if (state_reg == ST_APPLY) n_reg <= n_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            cmd_reg  <= s_tdata[CMD_W-1:0];
            page_reg <= s_tdata[CMD_W +: PAGE_BITS];
            tf_reg   <= s_tdata[CMD_W+PAGE_BITS +: FRAME_W];
        end
        if (state_reg == ST_MATCH) begin
            match_vec_reg <= tag_match_vec;
            free_vec_reg  <= unpinned_vec;
        end
        if (state_reg == ST_PICK) begin
            hit_f_reg     <= hit_f;
            hit_found_reg <= hit_found;
            vic_pos_reg   <= vic_pos;
            vic_found_reg <= vic_found;
            key_reg       <= (cmd_reg == CMD_SET_DIRTY || cmd_reg == CMD_UNSET_DIRTY)
                             ? FW'(tf_reg) : hit_f;
        end
        if (state_reg == ST_LOCATE) loc_pos_reg <= loc_pos;
        if (state_reg == ST_APPLY) begin
            res_frame_reg  <= res_frame;
            res_hit_reg    <= res_hit;
            res_read_reg   <= res_read;
            res_wb_reg     <= res_wb;
            res_evict_reg  <= res_evict;
            res_status_reg <= res_status;
            res_alloc_reg  <= COUNT_W'(n_next);
        end
    end

    assign m_tdata = OUT_DW'({res_alloc_reg, res_status_reg, res_evict_reg,
                              res_wb_reg, res_read_reg, res_hit_reg, res_frame_reg});

endmodule
